/* sv/stop_and_wait_link_endpoint_top_defines.svh */
// assertion macros for the stop-and-wait link endpoint
`ifndef STOP_AND_WAIT_LINK_ENDPOINT_TOP_DEFINES_SVH
`define STOP_AND_WAIT_LINK_ENDPOINT_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SAWL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sawl check failed");

// next-cycle implication, checked out of reset
`define SAWL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sawl check failed");

`endif

/* sv/sawl_pkg.sv */
// types and constants shared by the stop-and-wait link endpoint
package sawl_pkg;

    localparam int SEQ_W  = 31;
    localparam int WORD_W = 32;
    localparam int TMO_W  = 8;
    localparam int CIDX_W = 2;

    localparam logic [SEQ_W-1:0] SEQ_ONE = SEQ_W'(1);

    typedef enum logic [1:0] {
        ACT_ROUND_START = 2'd0,
        ACT_DATA        = 2'd1,
        ACT_ACK         = 2'd2,
        ACT_ROUND_END   = 2'd3
    } t_action;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    localparam logic [CIDX_W-1:0] CFG_IS_SENDER = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_TIMEOUT   = CIDX_W'(1);

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(4);

    typedef struct packed {
        t_action                   action;
        logic signed [WORD_W-1:0]  frame_number;
        logic [WORD_W-1:0]         round_now;
    } t_in_item;

    typedef struct packed {
        logic               send_valid;
        logic               send_kind;
        logic [SEQ_W-1:0]   send_number;
        logic [WORD_W-1:0]  send_round;
        logic [WORD_W-1:0]  frames_sent_total;
        logic [WORD_W-1:0]  requests_done_total;
        logic [SEQ_W-1:0]   highest_delivered;
    } t_out_item;

    typedef struct packed {
        logic              is_sender;
        logic [TMO_W-1:0]  timeout_rounds;
    } t_cfg;

    typedef struct packed {
        logic              waiting;
        logic [SEQ_W-1:0]  outstanding;
    } t_status;

endpackage

/* sv/sawl_engine.sv */
// protocol state and per-request update of the stop-and-wait endpoint
module sawl_engine
    import sawl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_advance,
    input  t_in_item   i_req,
    output t_out_item  o_res,
    output t_status    o_status
);

    logic               r_waiting;
    logic [SEQ_W-1:0]   r_next;
    logic [SEQ_W-1:0]   r_outstanding;
    logic [SEQ_W-1:0]   r_delivered;
    logic [WORD_W-1:0]  r_last;
    logic [WORD_W-1:0]  r_sent;
    logic [WORD_W-1:0]  r_sat;

    logic               n_waiting;
    logic [SEQ_W-1:0]   n_next;
    logic [SEQ_W-1:0]   n_outstanding;
    logic [SEQ_W-1:0]   n_delivered;
    logic [WORD_W-1:0]  n_last;
    logic [WORD_W-1:0]  n_sent;
    logic [WORD_W-1:0]  n_sat;

    logic [SEQ_W-1:0]   num;
    logic               neg;
    logic [SEQ_W-1:0]   next_inc;
    logic [WORD_W:0]    deadline;
    logic               issue;
    logic               ack;
    logic               resend;
    logic               sat;
    logic               send;

    assign num      = i_req.frame_number[SEQ_W-1:0];
    assign neg      = i_req.frame_number[WORD_W-1];
    assign next_inc = r_next + SEQ_ONE;
    assign deadline = {1'b0, r_last} + (WORD_W+1)'(i_cfg.timeout_rounds);

    // event decode
    always_comb begin
        issue  = 1'b0;
        ack    = 1'b0;
        resend = 1'b0;
        sat    = 1'b0;
        case (i_req.action)
            ACT_ROUND_START: begin
                issue = i_cfg.is_sender && !r_waiting && (r_next == SEQ_ONE);
            end
            ACT_DATA: begin
                ack = !neg;
            end
            ACT_ACK: begin
                sat   = i_cfg.is_sender && r_waiting && !neg && (num == r_outstanding);
                issue = sat;
            end
            ACT_ROUND_END: begin
                resend = i_cfg.is_sender && r_waiting
                         && (deadline < {1'b0, i_req.round_now})
                         && (r_outstanding != '0);
            end
            default: begin
            end
        endcase
    end

    assign send = issue || ack || resend;

    // state update
    always_comb begin
        n_waiting     = r_waiting;
        n_next        = r_next;
        n_outstanding = r_outstanding;
        n_delivered   = r_delivered;
        n_last        = r_last;
        n_sent        = r_sent;
        n_sat         = r_sat;
        if (issue) begin
            n_outstanding = r_next;
            n_waiting     = 1'b1;
            n_next        = (next_inc == '0) ? SEQ_ONE : next_inc;
        end
        if (sat) begin
            n_sat = r_sat + WORD_W'(1);
        end
        if (ack && (num > r_delivered)) begin
            n_delivered = num;
        end
        if (send) begin
            n_sent = r_sent + WORD_W'(1);
            n_last = i_req.round_now;
        end
    end

    // result
    always_comb begin
        o_res                     = '0;
        o_res.send_valid          = send;
        if (send) begin
            o_res.send_kind   = ack ? KIND_ACK : KIND_DATA;
            o_res.send_number = issue ? r_next : (ack ? num : r_outstanding);
            o_res.send_round  = i_req.round_now;
        end
        o_res.frames_sent_total   = n_sent;
        o_res.requests_done_total = n_sat;
        o_res.highest_delivered   = n_delivered;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting     <= 1'b0;
            r_next        <= SEQ_ONE;
            r_outstanding <= '0;
            r_delivered   <= '0;
            r_last        <= '0;
            r_sent        <= '0;
            r_sat         <= '0;
        end else if (i_advance) begin
            r_waiting     <= n_waiting;
            r_next        <= n_next;
            r_outstanding <= n_outstanding;
            r_delivered   <= n_delivered;
            r_last        <= n_last;
            r_sent        <= n_sent;
            r_sat         <= n_sat;
        end
    end

    assign o_status.waiting     = r_waiting;
    assign o_status.outstanding = r_outstanding;

endmodule

/* sv/stop_and_wait_link_endpoint_top.sv */
// top level of the stop-and-wait link endpoint: request/result registers and config
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  out      | output    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//  cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  one request per cycle sustained while the output is not stalled; a taken request
//  goes to the request register, then to the result register after the state update
//  the state update of one request is a single compare/add stage
//  a stalled result holds the result register and, one request later, the input
//  synchronous active-low reset clears state and config to defaults
`include "stop_and_wait_link_endpoint_top_defines.svh"

module stop_and_wait_link_endpoint_top
    import sawl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [TMO_W-1:0]   i_cfg_data
);

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    t_cfg       r_cfg;

    logic       advance;
    t_out_item  res;
    t_status    status;
    logic       out_clean;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    sawl_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_advance (advance),
        .i_req     (r_in),
        .o_res     (res),
        .o_status  (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.is_sender      <= 1'b0;
            r_cfg.timeout_rounds <= TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IS_SENDER: r_cfg.is_sender      <= i_cfg_data[0];
                CFG_TIMEOUT:   r_cfg.timeout_rounds <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign out_clean = (o_out_data.send_number == '0) && (o_out_data.send_round == '0)
                       && (o_out_data.send_kind == KIND_DATA);

    `SAWL_ASSERT_NOW(a_idle_result_clean, o_out_valid && !o_out_data.send_valid, out_clean)
    `SAWL_ASSERT_NOW(a_full_stall_blocks, r_in_valid && o_out_valid && !i_out_ready, !o_in_ready)
    `SAWL_ASSERT_NOW(a_waiting_has_number, status.waiting, status.outstanding != '0)
    `SAWL_ASSERT_NEXT(a_take_fills_result, advance, o_out_valid)

endmodule
